>>> sv/midi_note_route_tracker_defines.svh
// assertion macros for the note route tracker checker
`ifndef MIDI_NOTE_ROUTE_TRACKER_DEFINES_SVH
`define MIDI_NOTE_ROUTE_TRACKER_DEFINES_SVH

// same-cycle implication
`define MNRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MNRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mnrt_pkg.sv
// shared types and constants for the note route tracker
package mnrt_pkg;

  localparam int SLOTS    = 2048;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [7:0] KIND_MASK   = 8'hf0;
  localparam logic [7:0] CHAN_MASK   = 8'h0f;
  localparam logic [7:0] KIND_NOTEON = 8'h90;
  localparam logic [7:0] KIND_NOTEOFF = 8'h80;

  localparam logic [1:0] MODE_INTERNAL  = 2'd0;
  localparam logic [1:0] MODE_MIDI_ONLY = 2'd2;

  typedef enum logic [1:0] {
    MSG_OTHER,
    MSG_NOTE_ON,
    MSG_NOTE_OFF
  } msg_kind_t;

  typedef struct packed {
    msg_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        status;
    logic [6:0]        data_one;
    logic [6:0]        data_two;
    logic [31:0]       offset;
  } item_t;

endpackage

>>> sv/mnrt_front.sv
// front end: input handshake and message classification
module mnrt_front
  import mnrt_pkg::*;
(
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_status_byte,
  input  logic [6:0]  in_data_one,
  input  logic [6:0]  in_data_two,
  input  logic [31:0] in_time_offset,
  input  logic        q_full,
  input  logic        clr_busy,
  output logic        push,
  output item_t       push_item
);

  logic [7:0] kind_bits;
  logic [7:0] chan_bits;
  logic       vel_zero;

  always_comb begin
    kind_bits = in_status_byte & KIND_MASK;
    chan_bits = in_status_byte & CHAN_MASK;
    vel_zero  = (in_data_two == 7'd0);

    push_item.kind = MSG_OTHER;
    if ((kind_bits == KIND_NOTEON) && !vel_zero) begin
      push_item.kind = MSG_NOTE_ON;
    end else if ((kind_bits == KIND_NOTEOFF) || (kind_bits == KIND_NOTEON)) begin
      push_item.kind = MSG_NOTE_OFF;
    end
    push_item.slot     = {chan_bits[3:0], in_data_one};
    push_item.status   = in_status_byte;
    push_item.data_one = in_data_one;
    push_item.data_two = in_data_two;
    push_item.offset   = in_time_offset;
  end

  // no items while the queue is full, while the note maps are being cleared or in reset
  assign in_stall = q_full | clr_busy | !rst_n;
  assign push     = in_valid & ~in_stall;

endmodule

>>> sv/mnrt_queue.sv
// short item queue between front and back
module mnrt_queue
  import mnrt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  q_valid,
  output logic  q_full,
  output item_t q_item
);

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_item  = slot_r[rd_ptr_r];

endmodule

>>> sv/mnrt_back.sv
// back end: note map lookup and update, routing decision, output register
module mnrt_back
  import mnrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_route_mode,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  output logic        clr_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_forward_valid,
  output logic [7:0]  out_status,
  output logic [6:0]  out_data_one,
  output logic [6:0]  out_data_two,
  output logic [31:0] out_offset,
  output logic        out_play_inside
);

  // bit 1 external map, bit 0 internal map
  logic [1:0]        map_mem [SLOTS];

  logic [1:0]        mode_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic              b_vld_r, b_vld_nxt;
  item_t             b_item_r;
  logic [1:0]        b_map_r;

  logic              out_vld_r, out_vld_nxt;
  logic              fwd_r;
  logic              play_r;
  logic [7:0]        status_r;
  logic [6:0]        d1_r;
  logic [6:0]        d2_r;
  logic [31:0]       offs_r;

  logic              b_adv;
  logic              b_we;
  logic              fwd;
  logic              play;
  logic [1:0]        map_new;
  logic              bypass;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_addr;
  logic [1:0]        mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INTERNAL;
    end else if (cfg_write_en) begin
      mode_r <= cfg_route_mode;
    end
  end

  // clearing pass over the note maps after reset
  always_comb begin
    clr_cnt_nxt  = clr_busy_r ? clr_cnt_r + SLOT_W'(1) : clr_cnt_r;
    clr_busy_nxt = clr_busy_r && (clr_cnt_r != SLOT_W'(SLOTS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // routing decision for the item in the lookup stage
  always_comb begin
    fwd     = 1'b0;
    play    = 1'b1;
    map_new = b_map_r;
    if (mode_r != MODE_INTERNAL) begin
      case (b_item_r.kind)
        MSG_NOTE_ON: begin
          fwd        = 1'b1;
          map_new[1] = 1'b1;
        end
        MSG_NOTE_OFF: begin
          fwd        = b_map_r[1];
          map_new[1] = 1'b0;
        end
        default: begin
          fwd = 1'b1;
        end
      endcase
      if (mode_r == MODE_MIDI_ONLY) begin
        case (b_item_r.kind)
          MSG_NOTE_ON:  play = 1'b0;
          MSG_NOTE_OFF: play = b_map_r[0];
          default:      play = 1'b1;
        endcase
      end
      if (play && (b_item_r.kind == MSG_NOTE_ON)) begin
        map_new[0] = 1'b1;
      end
      if (play && (b_item_r.kind == MSG_NOTE_OFF)) begin
        map_new[0] = 1'b0;
      end
    end
  end

  always_comb begin
    b_adv     = b_vld_r && (!out_vld_r || !out_stall);
    b_we      = b_adv && (mode_r != MODE_INTERNAL) && (b_item_r.kind != MSG_OTHER);
    pop       = q_valid && !clr_busy_r && (!b_vld_r || b_adv);
    b_vld_nxt = pop || (b_vld_r && !b_adv);
    bypass    = b_we && (b_item_r.slot == q_item.slot);
    mem_we    = clr_busy_r || b_we;
    mem_addr  = clr_busy_r ? clr_cnt_r : b_item_r.slot;
    mem_wdata = clr_busy_r ? 2'b00 : map_new;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_addr] <= mem_wdata;
    end
    if (pop) begin
      b_map_r <= bypass ? map_new : map_mem[q_item.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item_r <= q_item;
    end
  end

  // output register
  assign out_vld_nxt = b_adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      fwd_r    <= fwd;
      play_r   <= play;
      status_r <= fwd ? b_item_r.status : 8'd0;
      d1_r     <= fwd ? b_item_r.data_one : 7'd0;
      d2_r     <= fwd ? b_item_r.data_two : 7'd0;
      offs_r   <= fwd ? b_item_r.offset : 32'd0;
    end
  end

  assign clr_busy          = clr_busy_r;
  assign out_valid         = out_vld_r;
  assign out_forward_valid = fwd_r;
  assign out_play_inside   = play_r;
  assign out_status        = status_r;
  assign out_data_one      = d1_r;
  assign out_data_two      = d2_r;
  assign out_offset        = offs_r;

endmodule

>>> sv/midi_note_route_tracker.sv
// top level of the midi note route tracker
//
//  port group | dir | handshake          | payload
//  in_        | in  | in_valid/in_stall  | status_byte, data_one, data_two, time_offset
//  out_       | out | out_valid/out_stall| forward_valid, status, data_ones/twos, offset, play
//  cfg_       | in  | cfg_write_en       | cfg_route_mode
//
//  one item per cycle sustained while out_stall is low; an accepted item passes the
//  queue, the registered note map read and the output register before out_valid
//  after reset a clearing pass over all 2048 note map slots holds in_stall high; config writes taken
//  a four-item queue lets out_stall back up without stalling the input at once
//  back-to-back items on the same note are forwarded past the map write
module midi_note_route_tracker
  import mnrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_route_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_status_byte,
  input  logic [6:0]  in_data_one,
  input  logic [6:0]  in_data_two,
  input  logic [31:0] in_time_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_forward_valid,
  output logic [7:0]  out_status,
  output logic [6:0]  out_data_one,
  output logic [6:0]  out_data_two,
  output logic [31:0] out_offset,
  output logic        out_play_inside
);

  logic  push;
  item_t push_item;
  logic  pop;
  logic  q_valid;
  logic  q_full;
  item_t q_item;
  logic  clr_busy;

  mnrt_front u_front (
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_status_byte (in_status_byte),
    .in_data_one    (in_data_one),
    .in_data_two    (in_data_two),
    .in_time_offset (in_time_offset),
    .q_full         (q_full),
    .clr_busy       (clr_busy),
    .push           (push),
    .push_item      (push_item)
  );

  mnrt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  mnrt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_route_mode    (cfg_route_mode),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .clr_busy          (clr_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_forward_valid (out_forward_valid),
    .out_status        (out_status),
    .out_data_one      (out_data_one),
    .out_data_two      (out_data_two),
    .out_offset        (out_offset),
    .out_play_inside   (out_play_inside)
  );

endmodule

>>> sv/mnrt_checker.sv
// port-level checker for the note route tracker, bound to the top level
`include "midi_note_route_tracker_defines.svh"

module mnrt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_forward_valid,
  input logic [7:0]  out_status,
  input logic [6:0]  out_data_one,
  input logic [6:0]  out_data_two,
  input logic [31:0] out_offset
);

  `MNRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled item dropped")

  `MNRT_ASSERT_NEXT(a_offs_hold, out_valid && out_stall, $stable(out_offset), "stalled offset moved")

  `MNRT_ASSERT_NOW(a_drop_zero, out_valid && !out_forward_valid, out_status == 8'd0 && out_data_one == 7'd0 && out_data_two == 7'd0 && out_offset == 32'd0, "unforwarded item carries payload")

  `MNRT_ASSERT_NOW(a_clr_stall, $past(!rst_n), in_stall && !out_valid, "item taken during map clear")

endmodule

bind midi_note_route_tracker mnrt_checker u_mnrt_checker (.*);
